>>> rtl/core/dag_edge_source_generator_core_macros.svh
// Assertion macros used by the edge source generator core.
`ifndef DAG_EDGE_SOURCE_GENERATOR_CORE_MACROS_SVH
`define DAG_EDGE_SOURCE_GENERATOR_CORE_MACROS_SVH

// Check a condition at every clock edge out of reset.
`define DESG_ASSERT_NOW(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("edge source generator: invariant violated");

// Check a consequent sequence whenever an antecedent holds.
`define DESG_ASSERT_SEQ(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> cons) \
        else $error("edge source generator: sequence violated");

`endif

>>> rtl/core/desg_pkg.sv
// Shared types and constants of the edge source generator.
package desg_pkg;

    typedef enum logic [1:0] {
        FUNC_CATENA      = 2'd0,
        FUNC_SLIDING_REV = 2'd1,
        FUNC_SLIDING_CAT = 2'd2,
        FUNC_REVERSE     = 2'd3
    } t_func;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int ROW_LOG2_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH_LOG2   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CATENA3_FIRST_ROW = 1'd1;

    localparam logic [ROW_LOG2_W-1:0] ROW_LOG2_RESET = 5'd7;
    localparam logic                  CATENA3_RESET  = 1'b0;

    localparam logic [ROW_LOG2_W-1:0] FIRST_ROW_MIN_LOG2 = 5'd3;
    localparam logic [ROW_LOG2_W-1:0] FIRST_ROW_SHRINK   = 5'd2;

endpackage

>>> rtl/core/dag_edge_source_generator_core.sv
// Edge source generator: pipelined source lookup for a password-hash dependency graph.
// Command channel: an item (i_position, i_func) is taken at a rising edge where
// start is high and busy is low. busy is high only during reset and the cycle
// after it, so one item is taken every cycle in normal operation.
// Result channel: o_done marks o_source_position / o_has_edge for exactly one
// cycle; the receiver cannot stall it. Each item passes the stage 1 and stage 2
// registers and its result is driven from the output register, in order, one
// result per item, one per cycle sustained.
// Stages: leading-one search and Catena row check, then per-mode operand and
// bit reversal, then window select and final compare into the output word.
// Configuration: i_cfg_valid / o_cfg_ready write row_length_log2 (index 0) or
// catena3_first_row (index 1) from i_cfg_data; write only while the pipeline
// is empty. Reset (synchronous, active low) restores row_length_log2 = 7 and
// catena3_first_row = 0 and drops every word in flight.
module dag_edge_source_generator_core
    import desg_pkg::*;
#(
    parameter int POS_BITS = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [POS_BITS-1:0]   i_position,
    input  logic [1:0]            i_func,
    output logic                  o_done,
    output logic [POS_BITS-1:0]   o_source_position,
    output logic                  o_has_edge,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int KW = $clog2(POS_BITS);
    localparam int W  = POS_BITS + 2;

    logic                  r_busy;
    logic [ROW_LOG2_W-1:0] r_row_log2;
    logic                  r_catena3;

    // stage 1
    logic                  r1_valid;
    logic [POS_BITS-1:0]   r1_pos;
    t_func                 r1_func;
    logic [KW-1:0]         r1_k;
    logic [KW-1:0]         r1_cat_l;
    logic                  r1_cat_ok;
    logic [KW-1:0]         n_k;
    logic [ROW_LOG2_W-1:0] n_l2;
    logic                  n_row_nz;
    logic                  n_first_ok;

    // stage 2
    logic                  r2_valid;
    logic [POS_BITS-1:0]   r2_pos;
    t_func                 r2_func;
    logic [POS_BITS-1:0]   r2_rev;
    logic [POS_BITS-1:0]   r2_m;
    logic [POS_BITS-1:0]   r2_base;
    logic                  r2_ok;
    logic [POS_BITS-1:0]   w_rev;
    logic [POS_BITS-1:0]   w_m;
    logic [POS_BITS-1:0]   w_base;
    logic                  w_ok;

    // stage 3
    logic                  r_done;
    logic [POS_BITS-1:0]   r_src;
    logic                  r_has_edge;
    logic [W-1:0]          s_p;
    logic [W-1:0]          s_m;
    logic [W-1:0]          s_rev;
    logic [W-1:0]          s_r;
    logic [W-1:0]          s_src;
    logic                  s_edge;

    logic                  accept;
    logic [POS_BITS:0]     s_src_inc;

    assign busy        = r_busy;
    assign o_cfg_ready = !r_busy;
    assign accept      = start && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_row_log2 <= ROW_LOG2_RESET;
            r_catena3  <= CATENA3_RESET;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_valid && !r_busy) begin
                case (i_cfg_index)
                    CFG_ROW_LENGTH_LOG2:   r_row_log2 <= i_cfg_data[ROW_LOG2_W-1:0];
                    CFG_CATENA3_FIRST_ROW: r_catena3  <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // stage 1: leading one and Catena row selection
    always_comb begin
        n_k = '0;
        for (int i = 1; i < POS_BITS; i++) begin
            if (i_position[i]) begin
                n_k = KW'(i);
            end
        end
    end

    assign n_l2       = r_row_log2 - FIRST_ROW_SHRINK;
    assign n_row_nz   = (i_position >> r_row_log2) != '0;
    assign n_first_ok = r_catena3 && (r_row_log2 >= FIRST_ROW_MIN_LOG2)
                        && ((i_position >> n_l2) != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= accept;
        end
        r1_pos    <= i_position;
        r1_func   <= t_func'(i_func);
        r1_k      <= n_k;
        r1_cat_ok <= n_row_nz || n_first_ok;
        // hold only the low bits: a valid row log2 is always below POS_BITS here
        r1_cat_l  <= n_row_nz ? r_row_log2[KW-1:0] : n_l2[KW-1:0];
    end

    // stage 2: operand select and bit reversal
    desg_operand #(
        .POS_BITS (POS_BITS)
    ) u_operand (
        .i_pos    (r1_pos),
        .i_func   (r1_func),
        .i_k      (r1_k),
        .i_cat_l  (r1_cat_l),
        .i_cat_ok (r1_cat_ok),
        .o_rev    (w_rev),
        .o_m      (w_m),
        .o_base   (w_base),
        .o_ok     (w_ok)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r2_pos  <= r1_pos;
        r2_func <= r1_func;
        r2_rev  <= w_rev;
        r2_m    <= w_m;
        r2_base <= w_base;
        r2_ok   <= w_ok;
    end

    // stage 3: window select and drop sources that are not below position - 1
    assign s_p   = {2'b00, r2_pos};
    assign s_m   = {2'b00, r2_m};
    assign s_rev = {2'b00, r2_rev};
    assign s_r   = s_m + s_rev;

    always_comb begin
        s_src = '0;
        case (r2_func)
            FUNC_CATENA: begin
                s_src = {2'b00, r2_base} + s_rev;
            end
            FUNC_SLIDING_REV: begin
                s_src = (s_rev + W'(1) >= s_p - s_m) ? s_rev : s_rev + s_m;
            end
            FUNC_SLIDING_CAT: begin
                if (s_r + W'(1) + (s_m << 1) < s_p) begin
                    s_src = s_r + (s_m << 1);
                end else if (s_r + W'(1) + s_m < s_p) begin
                    s_src = s_r + s_m;
                end else begin
                    s_src = s_r;
                end
            end
            FUNC_REVERSE: begin
                s_src = s_rev;
            end
            default: begin
                s_src = '0;
            end
        endcase
    end

    assign s_edge = r2_ok && (s_src + W'(1) < s_p);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done     <= 1'b0;
            r_src      <= '0;
            r_has_edge <= 1'b0;
        end else begin
            r_done     <= r2_valid;
            r_has_edge <= s_edge;
            r_src      <= s_edge ? s_src[POS_BITS-1:0] : '0;
        end
    end

    assign o_done            = r_done;
    assign o_source_position = r_src;
    assign o_has_edge        = r_has_edge;

    assign s_src_inc = {1'b0, o_source_position} + 1'b1;

`include "dag_edge_source_generator_core_macros.svh"

    `DESG_ASSERT_SEQ(a_result_latency, start && !busy, ##3 o_done)
    `DESG_ASSERT_SEQ(a_src_earlier, o_done && o_has_edge, s_src_inc < {1'b0, $past(i_position, 3)})
    `DESG_ASSERT_NOW(a_no_edge_zero, (o_has_edge || (o_source_position == '0)))

endmodule

>>> rtl/core/desg_operand.sv
// Per-mode operand select and low-bit reversal for the edge source pipeline.
module desg_operand
    import desg_pkg::*;
#(
    parameter int POS_BITS = 20,
    localparam int KW = $clog2(POS_BITS),
    localparam int NW = $clog2(POS_BITS + 1)
) (
    input  logic [POS_BITS-1:0] i_pos,
    input  t_func               i_func,
    input  logic [KW-1:0]       i_k,
    input  logic [KW-1:0]       i_cat_l,
    input  logic                i_cat_ok,
    output logic [POS_BITS-1:0] o_rev,
    output logic [POS_BITS-1:0] o_m,
    output logic [POS_BITS-1:0] o_base,
    output logic                o_ok
);

    logic [POS_BITS-1:0] one;
    logic [KW-1:0]       k_m1;
    logic [POS_BITS-1:0] m_k;
    logic [POS_BITS-1:0] m_half;
    logic [POS_BITS-1:0] m_cat;
    logic [POS_BITS:0]   two_k1;
    logic [POS_BITS:0]   gap;
    logic [POS_BITS-1:0] v;
    logic [NW-1:0]       n;
    logic [POS_BITS-1:0] v_flip;

    assign one    = {{(POS_BITS-1){1'b0}}, 1'b1};
    assign k_m1   = i_k - 1'b1;
    assign m_k    = one << i_k;
    assign m_half = one << k_m1;
    assign m_cat  = one << i_cat_l;
    assign two_k1 = {1'b0, m_k} << 1;
    assign gap    = two_k1 - {1'b0, i_pos} - {1'b0, one};

    always_comb begin
        v      = '0;
        n      = '0;
        o_m    = '0;
        o_base = '0;
        o_ok   = 1'b0;
        case (i_func)
            FUNC_CATENA: begin
                v      = i_pos & (m_cat - one);
                n      = NW'(i_cat_l);
                o_base = (i_pos & ~(m_cat - one)) - m_cat;
                o_ok   = i_cat_ok;
            end
            FUNC_SLIDING_REV: begin
                v    = i_pos & (m_k - one);
                n    = NW'(i_k);
                o_m  = m_k;
                o_ok = (i_k != '0);
            end
            FUNC_SLIDING_CAT: begin
                v    = i_pos & (m_half - one);
                n    = NW'(k_m1);
                o_m  = m_half;
                o_ok = (i_k != '0);
            end
            FUNC_REVERSE: begin
                v    = gap[POS_BITS-1:0];
                n    = NW'(i_k);
                // need position >= 3
                o_ok = (i_k > KW'(1)) || ((i_k == KW'(1)) && i_pos[0]);
            end
            default: begin
                v    = '0;
                n    = '0;
                o_ok = 1'b0;
            end
        endcase
    end

    // reverse the full word, then drop the bits above the reversed field
    always_comb begin
        for (int i = 0; i < POS_BITS; i++) begin
            v_flip[i] = v[POS_BITS-1-i];
        end
    end

    assign o_rev = v_flip >> (NW'(POS_BITS) - n);

endmodule
